FILE: hdl/fsth_pkg.sv
// ----------------------------------------------------------------------------
// fsth_pkg
// Shared types and constants of the fan step table with hysteresis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fsth_pkg;

    localparam int MAX_STEPS_DEF    = 16;
    localparam int FAN_CHANNELS_DEF = 2;
    localparam int SENSORS          = 3;
    localparam int TEMP_W           = 8;
    localparam int TEMPS_W          = SENSORS * TEMP_W;
    localparam int RPM_W            = 16;
    localparam int ACTION_W         = 2;
    localparam int FAN_W            = 1;
    localparam int STEP_W           = 4;
    localparam int LEVEL_W          = 4;
    localparam int CFG_W            = 5;

    localparam logic [CFG_W-1:0] STEPS_IN_USE_RST = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE,
        ACT_WR_ON,
        ACT_WR_OFF,
        ACT_WR_RPM
    } t_action;

    // per-sensor result of the shared compare unit
    typedef struct packed {
        logic [SENSORS-1:0] lt;
        logic [SENSORS-1:0] gt;
    } t_cmp;

endpackage

`default_nettype wire

FILE: hdl/fsth_if.sv
// ----------------------------------------------------------------------------
// fsth interfaces
// Valid/ready channels for sample and table write requests, results and the config write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fsth_in_if;
    logic                               valid;
    logic                               ready;
    logic [fsth_pkg::ACTION_W-1:0]      action;
    logic signed [fsth_pkg::TEMP_W-1:0] pmic_temp;
    logic signed [fsth_pkg::TEMP_W-1:0] ssd_temp;
    logic signed [fsth_pkg::TEMP_W-1:0] chg_temp;
    logic [fsth_pkg::FAN_W-1:0]         fan;
    logic [fsth_pkg::STEP_W-1:0]        step;
    logic [fsth_pkg::RPM_W-1:0]         rpm_value;

    modport source (
        output valid, action, pmic_temp, ssd_temp, chg_temp, fan, step, rpm_value,
        input  ready
    );
    modport sink (
        input  valid, action, pmic_temp, ssd_temp, chg_temp, fan, step, rpm_value,
        output ready
    );
endinterface

interface fsth_out_if;
    logic                           valid;
    logic                           ready;
    logic [fsth_pkg::RPM_W-1:0]     fan_rpm;
    logic [fsth_pkg::LEVEL_W-1:0]   level;
    logic                           level_changed;

    modport source (
        output valid, fan_rpm, level, level_changed,
        input  ready
    );
    modport sink (
        input  valid, fan_rpm, level, level_changed,
        output ready
    );
endinterface

interface fsth_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fsth_pkg::CFG_W-1:0]     data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/fan_step_table_hysteresis.sv
// ----------------------------------------------------------------------------
// fan_step_table_hysteresis
// Fan level controller walking a loaded step table with on/off hysteresis.
// Sample request: compare, then a walk down or up one level at a time until a
// compare stops it or it reaches level 0 or the top step in use, then clamp,
// rpm read and done; the next request is taken back in idle once the result
// is in the output register. Table write request: write, then done.
// A stalled result in the output register holds the next request off.
// Reset: level 0, stored temperatures 0, steps in use 16; tables undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fan_step_table_hysteresis #(
    parameter int MAX_STEPS    = fsth_pkg::MAX_STEPS_DEF,
    parameter int FAN_CHANNELS = fsth_pkg::FAN_CHANNELS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fsth_in_if.sink   i_in,
    fsth_out_if.source o_out,
    fsth_cfg_if.sink  i_cfg
);

    localparam int LVL_W     = $clog2(MAX_STEPS);
    localparam int NU_W      = $clog2(MAX_STEPS + 1);
    localparam int RPM_DEPTH = MAX_STEPS * FAN_CHANNELS;
    localparam int RPM_AW    = (RPM_DEPTH > 1) ? $clog2(RPM_DEPTH) : 1;
    localparam int TW        = fsth_pkg::TEMPS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR,
        S_CMP,
        S_DN,
        S_UP,
        S_CLAMP,
        S_RPM,
        S_DONE
    } t_state;

    t_state                          r_state, n_state;
    logic [LVL_W-1:0]                r_lvl, n_lvl;
    logic [LVL_W-1:0]                r_before, n_before;
    logic [TW-1:0]                   r_last, n_last;
    logic [fsth_pkg::CFG_W-1:0]      r_steps, n_steps;
    fsth_pkg::t_action               r_act, n_act;
    logic [TW-1:0]                   r_t, n_t;
    logic [fsth_pkg::FAN_W-1:0]      r_fan, n_fan;
    logic [fsth_pkg::STEP_W-1:0]     r_step, n_step;
    logic [fsth_pkg::RPM_W-1:0]      r_rpm_val, n_rpm_val;
    logic [fsth_pkg::RPM_W-1:0]      r_res_rpm, n_res_rpm;
    logic                            r_res_chg, n_res_chg;
    logic                            r_out_valid, n_out_valid;
    logic [fsth_pkg::RPM_W-1:0]      r_out_rpm, n_out_rpm;
    logic [fsth_pkg::LEVEL_W-1:0]    r_out_level, n_out_level;
    logic                            r_out_chg, n_out_chg;

    logic [NU_W-1:0]                 n_used;
    logic [LVL_W-1:0]                lvl_max;
    logic [LVL_W-1:0]                lvl_clamped;
    logic                            step_ok;
    logic                            fan_ok;
    logic [TW-1:0]                   cmp_b;
    fsth_pkg::t_cmp                  cmp;
    logic [TW-1:0]                   on_rdata;
    logic [TW-1:0]                   off_rdata;
    logic [fsth_pkg::RPM_W-1:0]      rpm_rdata;
    logic                            on_we, off_we, rpm_we;
    logic [LVL_W-1:0]                thr_waddr;
    logic [RPM_AW-1:0]               rpm_waddr, rpm_raddr;

    // steps in use, held to 1..MAX_STEPS
    always_comb begin
        if (r_steps == '0) begin
            n_used = NU_W'(1);
        end else if (32'(r_steps) > MAX_STEPS) begin
            n_used = NU_W'(MAX_STEPS);
        end else begin
            n_used = NU_W'(r_steps);
        end
    end

    assign lvl_max     = LVL_W'(32'(n_used) - 32'd1);
    assign lvl_clamped = (r_lvl > lvl_max) ? lvl_max : r_lvl;
    assign step_ok     = 32'(r_step) < MAX_STEPS;
    assign fan_ok      = 32'(r_fan) < FAN_CHANNELS;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid         = r_out_valid;
    assign o_out.fan_rpm       = r_out_rpm;
    assign o_out.level         = r_out_level;
    assign o_out.level_changed = r_out_chg;

    // operand select for the shared compare unit
    always_comb begin
        case (r_state)
            S_DN:    cmp_b = off_rdata;
            S_UP:    cmp_b = on_rdata;
            default: cmp_b = r_last;
        endcase
    end

    fsth_cmp3 u_cmp (
        .i_a   (r_t),
        .i_b   (cmp_b),
        .o_res (cmp)
    );

    // table writes
    assign on_we     = (r_state == S_WR) && (r_act == fsth_pkg::ACT_WR_ON) && step_ok;
    assign off_we    = (r_state == S_WR) && (r_act == fsth_pkg::ACT_WR_OFF) && step_ok;
    assign rpm_we    = (r_state == S_WR) && (r_act == fsth_pkg::ACT_WR_RPM) && step_ok
                       && fan_ok;
    assign thr_waddr = LVL_W'(32'(r_step));
    assign rpm_waddr = RPM_AW'(32'(r_step) * FAN_CHANNELS
                               + (fan_ok ? 32'(r_fan) : 32'd0));
    // reads follow the next level so the registered data matches r_lvl in the cycle after
    assign rpm_raddr = RPM_AW'(32'(n_lvl) * FAN_CHANNELS
                               + (fan_ok ? 32'(r_fan) : 32'd0));

    fsth_ram #(.W(TW), .DEPTH(MAX_STEPS)) u_on_ram (
        .i_clk   (i_clk),
        .i_we    (on_we),
        .i_waddr (thr_waddr),
        .i_wdata (r_t),
        .i_raddr (n_lvl),
        .o_rdata (on_rdata)
    );

    fsth_ram #(.W(TW), .DEPTH(MAX_STEPS)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (thr_waddr),
        .i_wdata (r_t),
        .i_raddr (n_lvl),
        .o_rdata (off_rdata)
    );

    fsth_ram #(.W(fsth_pkg::RPM_W), .DEPTH(RPM_DEPTH)) u_rpm_ram (
        .i_clk   (i_clk),
        .i_we    (rpm_we),
        .i_waddr (rpm_waddr),
        .i_wdata (r_rpm_val),
        .i_raddr (rpm_raddr),
        .o_rdata (rpm_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_lvl       = r_lvl;
        n_before    = r_before;
        n_last      = r_last;
        n_steps     = r_steps;
        n_act       = r_act;
        n_t         = r_t;
        n_fan       = r_fan;
        n_step      = r_step;
        n_rpm_val   = r_rpm_val;
        n_res_rpm   = r_res_rpm;
        n_res_chg   = r_res_chg;
        n_out_valid = r_out_valid;
        n_out_rpm   = r_out_rpm;
        n_out_level = r_out_level;
        n_out_chg   = r_out_chg;

        if (i_cfg.valid) begin
            n_steps = i_cfg.data;
        end

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_act     = fsth_pkg::t_action'(i_in.action);
                    n_t       = {i_in.chg_temp, i_in.ssd_temp, i_in.pmic_temp};
                    n_fan     = i_in.fan;
                    n_step    = i_in.step;
                    n_rpm_val = i_in.rpm_value;
                    n_state   = (fsth_pkg::t_action'(i_in.action) == fsth_pkg::ACT_SAMPLE)
                                ? S_CMP : S_WR;
                end
            end
            S_WR: begin
                n_res_rpm = '0;
                n_res_chg = 1'b0;
                n_state   = S_DONE;
            end
            S_CMP: begin
                n_before = r_lvl;
                // a fall takes priority over a rise
                if (|cmp.lt) begin
                    n_state = (r_lvl != '0) ? S_DN : S_CLAMP;
                end else if ((|cmp.gt) && (32'(r_lvl) + 32'd1 < 32'(n_used))) begin
                    n_state = S_UP;
                end else begin
                    n_state = S_CLAMP;
                end
            end
            S_DN: begin
                if (&cmp.lt) begin
                    n_lvl = r_lvl - LVL_W'(1);
                    if (r_lvl == LVL_W'(1)) begin
                        n_state = S_CLAMP;
                    end
                end else begin
                    n_state = S_CLAMP;
                end
            end
            S_UP: begin
                // any sensor at or above its on threshold
                if (cmp.lt != '1) begin
                    n_lvl = r_lvl + LVL_W'(1);
                    if (32'(r_lvl) + 32'd2 >= 32'(n_used)) begin
                        n_state = S_CLAMP;
                    end
                end else begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_lvl     = lvl_clamped;
                n_res_chg = (lvl_clamped != r_before);
                n_last    = r_t;
                n_state   = S_RPM;
            end
            S_RPM: begin
                n_res_rpm = fan_ok ? rpm_rdata : '0;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rpm   = r_res_rpm;
                    n_out_level = fsth_pkg::LEVEL_W'(32'(r_lvl));
                    n_out_chg   = r_res_chg;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lvl       <= '0;
            r_last      <= '0;
            r_steps     <= fsth_pkg::STEPS_IN_USE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lvl       <= n_lvl;
            r_last      <= n_last;
            r_steps     <= n_steps;
            r_out_valid <= n_out_valid;
        end
        r_before    <= n_before;
        r_act       <= n_act;
        r_t         <= n_t;
        r_fan       <= n_fan;
        r_step      <= n_step;
        r_rpm_val   <= n_rpm_val;
        r_res_rpm   <= n_res_rpm;
        r_res_chg   <= n_res_chg;
        r_out_rpm   <= n_out_rpm;
        r_out_level <= n_out_level;
        r_out_chg   <= n_out_chg;
    end

`ifndef SYNTHESIS
    a_dn_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN) |-> (r_lvl != '0))
        else $error("walk down entered at level zero");

    a_up_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP) |-> (32'(r_lvl) + 32'd1 < 32'(n_used)))
        else $error("walk up past the steps in use");

    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RPM) |-> (32'(r_lvl) < 32'(n_used)))
        else $error("level above steps in use after clamp");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");
`endif

endmodule

`default_nettype wire

FILE: hdl/fsth_ram.sv
// ----------------------------------------------------------------------------
// fsth_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsth_ram #(
    parameter int   W     = 8,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/fsth_cmp3.sv
// ----------------------------------------------------------------------------
// fsth_cmp3
// Shared compare unit: three signed temperature compares against one operand.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fsth_cmp3 (
    input  wire logic [fsth_pkg::TEMPS_W-1:0] i_a,
    input  wire logic [fsth_pkg::TEMPS_W-1:0] i_b,
    output fsth_pkg::t_cmp                    o_res
);

    always_comb begin
        for (int s = 0; s < fsth_pkg::SENSORS; s++) begin
            o_res.lt[s] = $signed(i_a[s*fsth_pkg::TEMP_W +: fsth_pkg::TEMP_W])
                        < $signed(i_b[s*fsth_pkg::TEMP_W +: fsth_pkg::TEMP_W]);
            o_res.gt[s] = $signed(i_a[s*fsth_pkg::TEMP_W +: fsth_pkg::TEMP_W])
                        > $signed(i_b[s*fsth_pkg::TEMP_W +: fsth_pkg::TEMP_W]);
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/fan_step_table_hysteresis_tb.sv
// ----------------------------------------------------------------------------
// fan_step_table_hysteresis_tb
// Loads the whole step table, then runs directed extremes, walks to the top
// and bottom, and random thermal traces with table rewrites under several
// steps-in-use settings and idle mixes. A scoreboard class predicts the
// level, the change flag and the rpm of every request and checks each result
// in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_step_table_hysteresis_tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int GAP_MAX     = 60;

    typedef struct packed {
        fsth_pkg::t_action action;
        logic [2:0][7:0]   temps;   // [0] pmic, [1] ssd, [2] charger
        logic              fan;
        logic [3:0]        step;
        logic [15:0]       rpm;
    } t_fan_req;

    typedef struct packed {
        logic [15:0] rpm;
        logic [3:0]  level;
        logic        changed;
    } t_fan_res;

    class fan_level_scoreboard;
        logic [3:0]      level;
        logic [2:0][7:0] last_t;
        logic [4:0]      steps_reg;
        logic [2:0][7:0] on_thr [16];
        logic [2:0][7:0] off_thr [16];
        logic [15:0]     rpm_tab [16][2];
        t_fan_res        expected_q [$];
        int              errors;
        int              samples;
        int              table_writes;
        int              level_moves;

        function new();
            level        = '0;
            last_t       = '0;
            steps_reg    = fsth_pkg::STEPS_IN_USE_RST;
            errors       = 0;
            samples      = 0;
            table_writes = 0;
            level_moves  = 0;
        endfunction

        function void set_steps(input logic [4:0] v);
            steps_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(input t_fan_req r);
            t_fan_res e;
            int       n;
            int       lvl;
            int       prev;
            bit       fell;
            bit       rose;
            bit       walking;
            bit       hit;
            e = '0;
            case (r.action)
                fsth_pkg::ACT_SAMPLE: begin
                    n = (steps_reg == 0) ? 1 : (steps_reg > 16) ? 16 : int'(steps_reg);
                    lvl  = level;
                    prev = level;
                    fell = 1'b0;
                    rose = 1'b0;
                    for (int s = 0; s < 3; s++) begin
                        if ($signed(r.temps[s]) < $signed(last_t[s])) fell = 1'b1;
                        if ($signed(r.temps[s]) > $signed(last_t[s])) rose = 1'b1;
                    end
                    walking = 1'b1;
                    // a fall takes priority over a rise in another sensor
                    if (fell) begin
                        while (walking && lvl > 0) begin
                            hit = 1'b1;
                            for (int s = 0; s < 3; s++)
                                if (!($signed(r.temps[s]) < $signed(off_thr[lvl][s])))
                                    hit = 1'b0;
                            if (hit) lvl--;
                            else walking = 1'b0;
                        end
                    end else if (rose) begin
                        while (walking && lvl + 1 < n) begin
                            hit = 1'b0;
                            for (int s = 0; s < 3; s++)
                                if ($signed(r.temps[s]) >= $signed(on_thr[lvl][s]))
                                    hit = 1'b1;
                            if (hit) lvl++;
                            else walking = 1'b0;
                        end
                    end
                    // lowered steps-in-use saturates the level
                    if (lvl > n - 1) lvl = n - 1;
                    level     = 4'(lvl);
                    last_t    = r.temps;
                    e.changed = (lvl != prev);
                    e.rpm     = rpm_tab[lvl][r.fan];
                    samples++;
                    if (e.changed) level_moves++;
                end
                fsth_pkg::ACT_WR_ON: begin
                    on_thr[r.step] = r.temps;
                    table_writes++;
                end
                fsth_pkg::ACT_WR_OFF: begin
                    off_thr[r.step] = r.temps;
                    table_writes++;
                end
                default: begin
                    rpm_tab[r.step][r.fan] = r.rpm;
                    table_writes++;
                end
            endcase
            e.level = level;
            expected_q.push_back(e);
        endfunction

        task report(input string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(input logic [15:0] rpm, input logic [3:0] lvl, input logic chg);
            t_fan_res e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result rpm=%0d level=%0d changed=%0b",
                                 rpm, lvl, chg));
                return;
            end
            e = expected_q.pop_front();
            if (rpm !== e.rpm)
                report($sformatf("fan_rpm got %0d want %0d", rpm, e.rpm));
            if (lvl !== e.level)
                report($sformatf("level got %0d want %0d", lvl, e.level));
            if (chg !== e.changed)
                report($sformatf("level_changed got %0b want %0b", chg, e.changed));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    int          idle_pct;
    int          stall_pct;
    int          hold_req;
    int          ambient;
    logic [2:0][7:0] prev_temps;
    int unsigned cycle_count = 0;

    fan_level_scoreboard board = new();

    fsth_in_if  in_if ();
    fsth_out_if out_if ();
    fsth_cfg_if cfg_if ();

    fan_step_table_hysteresis u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // nominal thresholds: on rises 7 degrees per step, off sits a little below
    function automatic int on_level(input int k, input int s);
        return 10 + 7 * k + 2 * s;
    endfunction

    function automatic int off_level(input int k, input int s);
        return on_level(k, s) - 3 - (k % 3);
    endfunction

    function automatic logic [7:0] to_temp(input int v);
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return v[7:0];
    endfunction

    function automatic t_fan_req mk_req(input fsth_pkg::t_action a, input int step,
                                        input int fan, input int p, input int s,
                                        input int c, input logic [15:0] rpm);
        t_fan_req r;
        r.action   = a;
        r.step     = 4'(step);
        r.fan      = 1'(fan);
        r.temps[0] = to_temp(p);
        r.temps[1] = to_temp(s);
        r.temps[2] = to_temp(c);
        r.rpm      = rpm;
        return r;
    endfunction

    function automatic t_fan_req make_sample();
        t_fan_req r;
        int       k;
        r.action = fsth_pkg::ACT_SAMPLE;
        r.fan    = 1'($urandom);
        r.step   = 4'($urandom);
        r.rpm    = 16'($urandom);
        k = $urandom_range(99);
        if (k < 8) begin
            r.temps = 24'($urandom);
        end else if (k < 14) begin
            r.temps = prev_temps;
        end else begin
            // correlated sensors drifting around a common ambient
            if (k < 22) ambient = int'($urandom_range(140)) - 15;
            else ambient = ambient + int'($urandom_range(24)) - 12;
            if (ambient > 125) ambient = 125;
            if (ambient < -20) ambient = -20;
            for (int s = 0; s < 3; s++)
                r.temps[s] = to_temp(ambient + int'($urandom_range(8)) - 4);
        end
        prev_temps = r.temps;
        return r;
    endfunction

    function automatic t_fan_req make_write();
        t_fan_req r;
        bit       wild;
        int       base;
        r.action = fsth_pkg::t_action'($urandom_range(int'(fsth_pkg::ACT_WR_RPM),
                                                      int'(fsth_pkg::ACT_WR_ON)));
        r.step   = 4'($urandom);
        r.fan    = 1'($urandom);
        r.rpm    = 16'($urandom);
        wild     = ($urandom_range(7) == 0);
        for (int s = 0; s < 3; s++) begin
            base = (r.action == fsth_pkg::ACT_WR_ON) ? on_level(r.step, s)
                                                     : off_level(r.step, s);
            r.temps[s] = wild ? 8'($urandom) : to_temp(base + int'($urandom_range(4)) - 2);
        end
        return r;
    endfunction

    task automatic send_request(input t_fan_req r);
        int gap;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= r.action;
        in_if.pmic_temp <= r.temps[0];
        in_if.ssd_temp  <= r.temps[1];
        in_if.chg_temp  <= r.temps[2];
        in_if.fan       <= r.fan;
        in_if.step      <= r.step;
        in_if.rpm_value <= r.rpm;
        @(posedge clk);
        while (in_if.ready !== 1'b1) @(posedge clk);
        board.note_request(r);
    endtask

    // only called right after an accepted request or at start of run
    task automatic reconfigure(input logic [4:0] v);
        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        cfg_if.valid <= 1'b0;
        board.set_steps(v);
    endtask

    task automatic run_phase(input logic [4:0] steps, input int idle, input int stall,
                             input int count, input bit pressure);
        reconfigure(steps);
        idle_pct  = idle;
        stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            if (pressure && i == count / 2) hold_req++;
            if ($urandom_range(99) < 15) send_request(make_write());
            else send_request(make_sample());
        end
    endtask

    // result side: check, then pick next ready
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
                board.check_result(out_if.fan_rpm, out_if.level, out_if.level_changed);
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        rst_n           <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.action    <= fsth_pkg::ACT_SAMPLE;
        in_if.pmic_temp <= '0;
        in_if.ssd_temp  <= '0;
        in_if.chg_temp  <= '0;
        in_if.fan       <= '0;
        in_if.step      <= '0;
        in_if.rpm_value <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_req   = 0;
        ambient    = 20;
        prev_temps = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every table entry before the first sample
        for (int k = 0; k < 16; k++) begin
            send_request(mk_req(fsth_pkg::ACT_WR_ON, k, 0, on_level(k, 0), on_level(k, 1),
                                on_level(k, 2), 16'($urandom)));
            send_request(mk_req(fsth_pkg::ACT_WR_OFF, k, 1, off_level(k, 0),
                                off_level(k, 1), off_level(k, 2), 16'($urandom)));
            send_request(mk_req(fsth_pkg::ACT_WR_RPM, k, 0, 0, 0, 0, 16'($urandom)));
            send_request(mk_req(fsth_pkg::ACT_WR_RPM, k, 1, 0, 0, 0, 16'($urandom)));
        end

        // unchanged temperatures, walk to the top, repeat, walk to the bottom
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 0, 0, 0, 0, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 15, 1, 127, 127, 127, 16'hffff));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 1, 127, 127, 127, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 0, -128, -128, -128, 16'h0000));
        // one sensor rises, then one falls while another rises
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 0, 40, -128, -128, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 1, 39, 127, -128, 16'h0000));
        // extreme thresholds on step 2 and extreme rpm values
        send_request(mk_req(fsth_pkg::ACT_WR_ON, 2, 0, 127, 127, 127, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_WR_OFF, 2, 1, -128, -128, -128, 16'hffff));
        send_request(mk_req(fsth_pkg::ACT_WR_RPM, 15, 1, 0, 0, 0, 16'hffff));
        send_request(mk_req(fsth_pkg::ACT_WR_RPM, 0, 0, 0, 0, 0, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 0, -128, -128, -128, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 1, 127, 127, 127, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 0, -128, -128, -128, 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_WR_ON, 2, 0, on_level(2, 0), on_level(2, 1),
                            on_level(2, 2), 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_WR_OFF, 2, 0, off_level(2, 0), off_level(2, 1),
                            off_level(2, 2), 16'h0000));
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 1, 127, 127, 127, 16'h0000));
        // shrink the table under a high level, then out-of-range register values
        reconfigure(5'd4);
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 0, 127, 127, 127, 16'h0000));
        reconfigure(5'd0);
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 1, 126, 126, 126, 16'h0000));
        reconfigure(5'd31);
        send_request(mk_req(fsth_pkg::ACT_SAMPLE, 0, 1, 127, 127, 127, 16'h0000));

        run_phase(5'd16, 0, 0, 250, 1'b0);
        run_phase(5'd0, 80, 0, 120, 1'b0);
        run_phase(5'd31, 0, 80, 250, 1'b1);
        run_phase(5'd5, 28, 28, 250, 1'b0);
        run_phase(5'd1, 0, 0, 80, 1'b0);
        run_phase(5'd17, 28, 28, 150, 1'b0);
        run_phase(5'd9, 80, 0, 150, 1'b0);

        in_if.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (25) @(posedge clk);

        $display("covered %0d requests: %0d samples, %0d table writes, %0d level changes",
                 board.samples + board.table_writes, board.samples, board.table_writes,
                 board.level_moves);
        $display("steps in use 0 to 31, sender and receiver idling up to 80 percent");
        if (board.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
